// ===== hdl/chenc_pkg.sv =====
// Shared widths, codes and defaults for the canonical Huffman encoder.
`timescale 1ns / 1ps

package chenc_pkg;

   localparam int ALPHABET_DEF     = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   localparam int MODE_W   = 2;
   localparam int SYM_W    = 8;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_LOAD   = 2'd0;
   localparam mode_type MODE_BUILD  = 2'd1;
   localparam mode_type MODE_ENCODE = 2'd2;
   localparam mode_type MODE_FLUSH  = 2'd3;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_TOO_LONG = 2'd1;
   localparam status_type STATUS_NO_CODE = 2'd2;

endpackage

// ===== hdl/chenc_if.sv =====
// Request and response channel interfaces of the canonical Huffman encoder.
`timescale 1ns / 1ps

interface chenc_req_if;
   logic                           valid;
   logic                           ready;
   chenc_pkg::mode_type            mode;
   logic [chenc_pkg::SYM_W-1:0]    symbol;
   logic [chenc_pkg::LEN_W-1:0]    code_length;

   modport source (output valid, output mode, output symbol, output code_length,
                   input ready);
   modport sink   (input valid, input mode, input symbol, input code_length,
                   output ready);
endinterface

interface chenc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [chenc_pkg::BYTE_W-1:0]   out_byte;
   logic                           byte_valid;
   logic                           last;
   chenc_pkg::status_type          status;

   modport source (output valid, output out_byte, output byte_valid, output last,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last,
                   input status, output ready);
endinterface

// ===== hdl/chenc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module chenc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/canonical_huffman_encoder.sv =====
// Canonical Huffman encoder: length/code table, code builder and byte packer.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    mode, symbol, code_length
//   rsp_chan  out  valid/ready    out_byte, byte_valid, last, status
//
// Build clears the length table, counts the symbols of each length, derives
// the start code of each length and then assigns a code to each symbol.
// After reset a clearing pass zeroes the symbol table.
// One transaction in flight; results leave through a one-deep output register.
`timescale 1ns / 1ps

module canonical_huffman_encoder #(
   parameter int ALPHABET     = chenc_pkg::ALPHABET_DEF,
   parameter int MAX_CODE_LEN = chenc_pkg::MAX_CODE_LEN_DEF
) (
   input  logic           clock,
   input  logic           reset,
   chenc_req_if.sink      req_chan,
   chenc_rsp_if.source    rsp_chan
);

   localparam int LEN_W = chenc_pkg::LEN_W;
   localparam int CW    = MAX_CODE_LEN;
   localparam int AW    = $clog2(ALPHABET);
   localparam int LAW   = $clog2(MAX_CODE_LEN + 1);
   localparam int CNTW  = $clog2(ALPHABET + 1);
   localparam int SW    = LEN_W + CW;
   localparam int AXW   = CNTW + CW;
   localparam int W     = CW + 7;
   localparam int RW    = $clog2(CW + 8);
   localparam int CSW   = CW + CNTW;

   localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_CODE_LEN);
   localparam logic [6:0]       CW7        = 7'(CW);
   localparam logic [AW-1:0]    LAST_SYM   = AW'(ALPHABET - 1);
   localparam logic [LAW-1:0]   LAST_LEN   = LAW'(MAX_CODE_LEN);
   localparam logic [8:0]       ALPHA9     = 9'(ALPHABET);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_M0_WR  = 4'd2;
   localparam logic [3:0] ST_RESP   = 4'd3;
   localparam logic [3:0] ST_FLUSH  = 4'd4;
   localparam logic [3:0] ST_BCLR   = 4'd5;
   localparam logic [3:0] ST_CN_RD  = 4'd6;
   localparam logic [3:0] ST_CN_LEN = 4'd7;
   localparam logic [3:0] ST_CN_WR  = 4'd8;
   localparam logic [3:0] ST_NX_RD  = 4'd9;
   localparam logic [3:0] ST_NX_WR  = 4'd10;
   localparam logic [3:0] ST_AS_RD  = 4'd11;
   localparam logic [3:0] ST_AS_LEN = 4'd12;
   localparam logic [3:0] ST_AS_WR  = 4'd13;
   localparam logic [3:0] ST_ENC_LD = 4'd14;
   localparam logic [3:0] ST_EMIT   = 4'd15;

   logic [3:0]                   state_ff, state_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [LAW-1:0]               lidx_ff, lidx_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [CW-1:0]                code_ff, code_in;
   logic [CNTW-1:0]              prev_cnt_ff, prev_cnt_in;
   chenc_pkg::status_type        status_ff, status_in;
   logic [LEN_W-1:0]             clen_ff, clen_in;
   logic [W-1:0]                 word_ff, word_in;
   logic [RW-1:0]                rem_ff, rem_in;
   logic [6:0]                   pend_ff, pend_in;
   logic [2:0]                   pcnt_ff, pcnt_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_byte_ff, rsp_byte_in;
   logic                         rsp_bvalid_ff, rsp_bvalid_in;
   logic                         rsp_last_ff, rsp_last_in;
   chenc_pkg::status_type        rsp_status_ff, rsp_status_in;

   logic                         s_we;
   logic [AW-1:0]                s_waddr, s_raddr;
   logic [SW-1:0]                s_wdata, s_rdata;
   logic                         a_we;
   logic [LAW-1:0]               a_waddr, a_raddr;
   logic [AXW-1:0]               a_wdata, a_rdata;

   logic [LEN_W-1:0]             s_len;
   logic [CW-1:0]                s_code;
   logic [CNTW-1:0]              a_cnt;
   logic [CW-1:0]                a_nc;
   logic                         s_len_ok;
   logic                         accept;
   logic                         sym_out;
   logic [AW-1:0]                req_addr;
   logic                         out_free;
   logic                         out_load;
   logic [6:0]                   enc_sh;
   logic [CW-1:0]                code_al;
   logic [W-1:0]                 enc_wide;
   logic [W-1:0]                 enc_word;
   logic [RW-1:0]                enc_n;
   logic [W-1:0]                 word_next;
   logic [CSW-1:0]               nx_sum;
   logic [CW-1:0]                nx_code;
   logic [CW-1:0]                len_mask;
   logic [RW-4:0]                rem_hi;

   chenc_ram #(.WIDTH(SW), .DEPTH(ALPHABET)) u_sym_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   chenc_ram #(.WIDTH(AXW), .DEPTH(MAX_CODE_LEN + 1)) u_len_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   assign {s_len, s_code} = s_rdata;
   assign {a_cnt, a_nc}   = a_rdata;
   assign s_len_ok  = (s_len != '0) && (s_len <= MAX_LEN);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign sym_out   = ({1'b0, req_chan.symbol} >= ALPHA9);
   assign req_addr  = req_chan.symbol[AW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign enc_sh    = CW7 - {1'b0, s_len};
   assign code_al   = s_code << enc_sh;
   assign enc_wide  = {code_al, 7'b0} >> pcnt_ff;
   assign enc_word  = {pend_ff, {CW{1'b0}}} | enc_wide;
   assign enc_n     = RW'(pcnt_ff) + RW'(s_len);
   assign word_next = word_ff << 8;
   assign nx_sum    = CSW'(code_ff) + CSW'(prev_cnt_ff);
   assign nx_code   = CW'(nx_sum << 1);
   assign len_mask  = ~({CW{1'b1}} << len_ff);
   assign rem_hi    = rem_ff[RW-1:3];

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      lidx_in       = lidx_ff;
      len_in        = len_ff;
      code_in       = code_ff;
      prev_cnt_in   = prev_cnt_ff;
      status_in     = status_ff;
      clen_in       = clen_ff;
      word_in       = word_ff;
      rem_in        = rem_ff;
      pend_in       = pend_ff;
      pcnt_in       = pcnt_ff;
      out_load      = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      s_we          = 1'b0;
      s_waddr       = idx_ff;
      s_wdata       = '0;
      s_raddr       = idx_ff;
      a_we          = 1'b0;
      a_waddr       = lidx_ff;
      a_wdata       = '0;
      a_raddr       = lidx_ff;

      case (state_ff)
         ST_INIT: begin
            s_we = 1'b1;
            if (idx_ff == LAST_SYM) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               s_raddr = req_addr;
               idx_in  = req_addr;
               case (req_chan.mode)
                  chenc_pkg::MODE_LOAD: begin
                     if (sym_out) begin
                        status_in = chenc_pkg::STATUS_NO_CODE;
                        state_in  = ST_RESP;
                     end else if (req_chan.code_length > MAX_LEN) begin
                        clen_in   = '0;
                        status_in = chenc_pkg::STATUS_TOO_LONG;
                        state_in  = ST_M0_WR;
                     end else begin
                        clen_in   = req_chan.code_length;
                        status_in = chenc_pkg::STATUS_OK;
                        state_in  = ST_M0_WR;
                     end
                  end
                  chenc_pkg::MODE_BUILD: begin
                     lidx_in  = '0;
                     state_in = ST_BCLR;
                  end
                  chenc_pkg::MODE_ENCODE: begin
                     if (sym_out) begin
                        status_in = chenc_pkg::STATUS_NO_CODE;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_ENC_LD;
                     end
                  end
                  default: state_in = ST_FLUSH;
               endcase
            end
         end
         ST_M0_WR: begin
            s_we     = 1'b1;
            s_wdata  = {clen_ff, s_code};
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_byte_in   = '0;
               rsp_bvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_byte_in   = {pend_ff, 1'b0};
               rsp_bvalid_in = (pcnt_ff != '0);
               rsp_last_in   = 1'b1;
               rsp_status_in = chenc_pkg::STATUS_OK;
               pend_in       = '0;
               pcnt_in       = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_BCLR: begin
            a_we = 1'b1;
            if (lidx_ff == LAST_LEN) begin
               idx_in   = '0;
               state_in = ST_CN_RD;
            end else begin
               lidx_in = lidx_ff + 1'b1;
            end
         end
         ST_CN_RD: begin
            state_in = ST_CN_LEN;
         end
         ST_CN_LEN: begin
            len_in  = s_len;
            a_raddr = s_len[LAW-1:0];
            if (s_len_ok) begin
               state_in = ST_CN_WR;
            end else if (idx_ff == LAST_SYM) begin
               lidx_in     = LAW'(1);
               code_in     = '0;
               prev_cnt_in = '0;
               state_in    = ST_NX_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_CN_RD;
            end
         end
         ST_CN_WR: begin
            a_we    = 1'b1;
            a_waddr = len_ff[LAW-1:0];
            a_wdata = {a_cnt + 1'b1, a_nc};
            if (idx_ff == LAST_SYM) begin
               lidx_in     = LAW'(1);
               code_in     = '0;
               prev_cnt_in = '0;
               state_in    = ST_NX_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_CN_RD;
            end
         end
         ST_NX_RD: begin
            state_in = ST_NX_WR;
         end
         ST_NX_WR: begin
            a_we        = 1'b1;
            a_wdata     = {a_cnt, nx_code};
            code_in     = nx_code;
            prev_cnt_in = a_cnt;
            if (lidx_ff == LAST_LEN) begin
               idx_in   = '0;
               state_in = ST_AS_RD;
            end else begin
               lidx_in  = lidx_ff + 1'b1;
               state_in = ST_NX_RD;
            end
         end
         ST_AS_RD: begin
            state_in = ST_AS_LEN;
         end
         ST_AS_LEN: begin
            len_in  = s_len;
            a_raddr = s_len[LAW-1:0];
            if (s_len_ok) begin
               state_in = ST_AS_WR;
            end else begin
               s_we    = 1'b1;
               s_wdata = {s_len, {CW{1'b0}}};
               if (idx_ff == LAST_SYM) begin
                  status_in = chenc_pkg::STATUS_OK;
                  state_in  = ST_RESP;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_AS_RD;
               end
            end
         end
         ST_AS_WR: begin
            s_we    = 1'b1;
            s_wdata = {len_ff, a_nc & len_mask};
            a_we    = 1'b1;
            a_waddr = len_ff[LAW-1:0];
            a_wdata = {a_cnt, a_nc + 1'b1};
            if (idx_ff == LAST_SYM) begin
               status_in = chenc_pkg::STATUS_OK;
               state_in  = ST_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_AS_RD;
            end
         end
         ST_ENC_LD: begin
            if (!s_len_ok) begin
               status_in = chenc_pkg::STATUS_NO_CODE;
               state_in  = ST_RESP;
            end else begin
               word_in  = enc_word;
               rem_in   = enc_n;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = chenc_pkg::STATUS_OK;
               if (rem_hi != '0) begin
                  rsp_byte_in   = word_ff[W-1 -: 8];
                  rsp_bvalid_in = 1'b1;
                  rsp_last_in   = (rem_hi == (RW-3)'(1));
                  word_in       = word_next;
                  rem_in        = rem_ff - RW'(8);
                  if (rem_hi == (RW-3)'(1)) begin
                     pend_in  = word_next[W-1 -: 7];
                     pcnt_in  = rem_ff[2:0];
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_byte_in   = '0;
                  rsp_bvalid_in = 1'b0;
                  rsp_last_in   = 1'b1;
                  pend_in       = word_ff[W-1 -: 7];
                  pcnt_in       = rem_ff[2:0];
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         pend_ff      <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lidx_ff       <= lidx_in;
      len_ff        <= len_in;
      code_ff       <= code_in;
      prev_cnt_ff   <= prev_cnt_in;
      status_ff     <= status_in;
      clen_ff       <= clen_in;
      word_ff       <= word_in;
      rem_ff        <= rem_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.byte_valid = rsp_bvalid_ff;
   assign rsp_chan.last       = rsp_last_ff;
   assign rsp_chan.status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("output register overwritten while a transaction is waiting");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bvalid_ff) |-> (rsp_byte_ff == '0))
      else $error("result without byte carries nonzero data");

   a_pend_aligned: assert property (@(posedge clock) disable iff (reset)
      (7'(pend_ff << pcnt_ff) == '0))
      else $error("pending bits beyond pending count");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && state_ff == ST_FLUSH) |=> (pcnt_ff == '0 && pend_ff == '0))
      else $error("flush left bits pending");
`endif

endmodule
